// ===== hw/rtl/uec_pkg.sv =====
// Shared types, constants and calendar helpers for the Unix time to calendar converter.
// Used by the stage modules and the top level.
package uec_pkg;

    // Calendar range
    localparam int FIRST_YEAR        = 1970;
    localparam int DEFAULT_LAST_YEAR = 2100;
    localparam int CENTURY_YEAR      = 2100;

    // A second of day is split as (seconds >> DAY_SHIFT) / DAY_ODD, since 86400 = 675 * 128.
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;

    // Reciprocal multipliers, rounded down, so an estimate is at most one below the quotient.
    localparam int DIV675_SHIFT  = 35;
    localparam longint DIV675_MUL = 50903316;
    localparam int DIV60_SHIFT   = 22;
    localparam int DIV60_MUL     = 69905;
    localparam int DIV7_SHIFT    = 19;
    localparam int DIV7_MUL      = 74898;
    localparam int DIV1461_SHIFT = 26;
    localparam int DIV1461_MUL   = 45933;

    // Four-year cycles are counted from 1968, a leap year, which lies 731 days before the epoch.
    localparam int CYCLE_BASE_YEAR = 1968;
    localparam int CYCLE_OFFSET    = 731;
    localparam int CYCLE_DAYS      = 1461;
    localparam int EPOCH_WEEKDAY   = 4;

    // One input word.
    typedef struct packed {
        logic signed [32:0] epoch_seconds;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic [2:0]  day_of_week;
        logic        beyond_limit;
    } out_word_t;

    // Gregorian leap rule, evaluated on constants only.
    function automatic bit is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days from the epoch to January 1st of the given year, evaluated on constants only.
    function automatic int days_before_year(input int y);
        int total;
        total = 0;
        for (int yy = FIRST_YEAR; yy < y; yy++)
        begin
            total += is_leap_year(yy) ? 366 : 365;
        end
        return total;
    endfunction

    // Day of year at which a month starts, months counted from zero.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== hw/rtl/uec_stream_if.sv =====
// Valid/ready stream interface that carries one word per handshake.
// The word type is a parameter; the converter uses the word types of uec_pkg.
interface uec_stream_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/uec_day_split.sv =====
// Two pipeline stages that split a non-negative timestamp into whole days and second of day.
// Depends on uec_pkg for the reciprocal constants.
module uec_day_split
    import uec_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] t,
    output logic [15:0] days,
    output logic [16:0] sod
);

    logic [24:0] x;
    logic [50:0] prod;
    logic [15:0] q_est_reg;
    logic [24:0] x_reg;
    logic [6:0]  lo_reg;
    logic [25:0] q_mul;
    logic [24:0] rem;
    logic        fix;
    logic [24:0] rem_fix;
    logic [15:0] days_reg;
    logic [15:0] days_next;
    logic [16:0] sod_reg;
    logic [16:0] sod_next;

    // First stage: estimate (t >> 7) / 675 through a reciprocal multiply.
    assign x    = t[31:DAY_SHIFT];
    assign prod = 51'(x) * 51'(DIV675_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_est_reg <= prod[DIV675_SHIFT +: 16];
            x_reg     <= x;
            lo_reg    <= t[DAY_SHIFT-1:0];
        end
    end

    // Second stage: the estimate is low by at most one, so one compare and subtract fixes it.
    always_comb
    begin
        q_mul     = 26'(q_est_reg) * 26'(DAY_ODD);
        rem       = x_reg - q_mul[24:0];
        fix       = rem >= 25'(DAY_ODD);
        rem_fix   = fix ? (rem - 25'(DAY_ODD)) : rem;
        days_next = q_est_reg + 16'(fix);
        sod_next  = {rem_fix[9:0], lo_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days = days_reg;
    assign sod  = sod_reg;

endmodule

// ===== hw/rtl/uec_time_split.sv =====
// Five pipeline stages that turn second of day into hour, minute and second, and days into
// weekday. Depends on uec_pkg for the reciprocal constants.
module uec_time_split
    import uec_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] sod,
    input  logic [15:0] days,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  wday
);

    logic [33:0] prod60;
    logic [15:0] w;
    logic [32:0] prod7;
    logic [10:0] q60_reg;
    logic [16:0] sod3_reg;
    logic [12:0] q7_reg;
    logic [15:0] w3_reg;

    logic [16:0] r60;
    logic        fix60;
    logic [10:0] mt_next;
    logic [5:0]  sec_next;
    logic [15:0] r7;
    logic [2:0]  wday_next;
    logic [10:0] mt4_reg;
    logic [5:0]  sec4_reg;
    logic [2:0]  wday4_reg;

    logic [27:0] prodh;
    logic [4:0]  hq_reg;
    logic [10:0] mt5_reg;
    logic [5:0]  sec5_reg;
    logic [2:0]  wday5_reg;

    logic [10:0] rh;
    logic        fixh;
    logic [4:0]  hour_next;
    logic [5:0]  min_next;
    logic [4:0]  hour6_reg;
    logic [5:0]  min6_reg;
    logic [5:0]  sec6_reg;
    logic [2:0]  wday6_reg;

    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [2:0]  wday_reg;

    // Estimate minute of day and weekday quotient.
    assign prod60 = 34'(sod) * 34'(DIV60_MUL);
    assign w      = days + 16'(EPOCH_WEEKDAY);
    assign prod7  = 33'(w) * 33'(DIV7_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q60_reg  <= prod60[DIV60_SHIFT +: 11];
            sod3_reg <= sod;
            q7_reg   <= prod7[DIV7_SHIFT +: 13];
            w3_reg   <= w;
        end
    end

    // Correct both estimates and take the remainders.
    always_comb
    begin
        r60       = sod3_reg - (17'(q60_reg) * 17'(60));
        fix60     = r60 >= 17'(60);
        mt_next   = q60_reg + 11'(fix60);
        sec_next  = fix60 ? 6'(r60 - 17'(60)) : r60[5:0];
        r7        = w3_reg - (16'(q7_reg) * 16'(7));
        wday_next = (r7 >= 16'(7)) ? 3'(r7 - 16'(7)) : r7[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mt4_reg   <= mt_next;
            sec4_reg  <= sec_next;
            wday4_reg <= wday_next;
        end
    end

    // Estimate the hour from minute of day.
    assign prodh = 28'(mt4_reg) * 28'(DIV60_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hq_reg    <= prodh[DIV60_SHIFT +: 5];
            mt5_reg   <= mt4_reg;
            sec5_reg  <= sec4_reg;
            wday5_reg <= wday4_reg;
        end
    end

    // Correct the hour and take the minute.
    always_comb
    begin
        rh        = mt5_reg - (11'(hq_reg) * 11'(60));
        fixh      = rh >= 11'(60);
        hour_next = hq_reg + 5'(fixh);
        min_next  = fixh ? 6'(rh - 11'(60)) : rh[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hour6_reg <= hour_next;
            min6_reg  <= min_next;
            sec6_reg  <= sec5_reg;
            wday6_reg <= wday5_reg;
        end
    end

    // Last stage lines the time fields up with the date pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hour_reg <= hour6_reg;
            min_reg  <= min6_reg;
            sec_reg  <= sec6_reg;
            wday_reg <= wday6_reg;
        end
    end

    assign hour   = hour_reg;
    assign minute = min_reg;
    assign second = sec_reg;
    assign wday   = wday_reg;

endmodule

// ===== hw/rtl/uec_date_split.sv =====
// Five pipeline stages that turn days since the epoch into year, month and day of month.
// Depends on uec_pkg for the calendar helpers and constants.
module uec_date_split
    import uec_pkg::*;
#(
    parameter int LAST_YEAR = DEFAULT_LAST_YEAR
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] days,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic        beyond
);

    // First day past the last year, and March 1st of the century year that skips a leap day.
    localparam logic [15:0] END_DAY = 16'(days_before_year(LAST_YEAR + 1));
    localparam logic [15:0] FIX_DAY = 16'(days_before_year(CENTURY_YEAR) + 59);

    logic [15:0] dfix;
    logic [31:0] prod;
    logic [5:0]  c3_reg;
    logic [15:0] d3_reg;
    logic        beyond3_reg;

    logic [15:0] r;
    logic        fix;
    logic [5:0]  c4_reg;
    logic [10:0] r4_reg;
    logic        beyond4_reg;

    logic [1:0]  yi;
    logic [8:0]  doy_next;
    logic [11:0] year5_reg;
    logic [8:0]  doy5_reg;
    logic        leap5_reg;
    logic        beyond5_reg;

    logic [3:0]  midx;
    logic [3:0]  midx6_reg;
    logic [11:0] year6_reg;
    logic [8:0]  doy6_reg;
    logic        leap6_reg;
    logic        beyond6_reg;

    logic [8:0]  day_off;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic        beyond_reg;

    // Rebase to 1968 and add the missing leap day after February of the century year, so
    // plain four-year cycles hold over the whole range; then estimate the cycle count.
    assign dfix = days + 16'(CYCLE_OFFSET) + 16'(days >= FIX_DAY);
    assign prod = 32'(dfix) * 32'(DIV1461_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg      <= prod[DIV1461_SHIFT +: 6];
            d3_reg      <= dfix;
            beyond3_reg <= days >= END_DAY;
        end
    end

    // Correct the cycle count and take the day within the cycle.
    assign r   = d3_reg - (16'(c3_reg) * 16'(CYCLE_DAYS));
    assign fix = r >= 16'(CYCLE_DAYS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg      <= c3_reg + 6'(fix);
            r4_reg      <= fix ? 11'(r - 16'(CYCLE_DAYS)) : r[10:0];
            beyond4_reg <= beyond3_reg;
        end
    end

    // Year within the cycle; the first year of each cycle is the leap year.
    always_comb
    begin
        priority if (r4_reg < 11'd366)
        begin
            yi       = 2'd0;
            doy_next = r4_reg[8:0];
        end
        else if (r4_reg < 11'd731)
        begin
            yi       = 2'd1;
            doy_next = 9'(r4_reg - 11'd366);
        end
        else if (r4_reg < 11'd1096)
        begin
            yi       = 2'd2;
            doy_next = 9'(r4_reg - 11'd731);
        end
        else
        begin
            yi       = 2'd3;
            doy_next = 9'(r4_reg - 11'd1096);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year5_reg   <= 12'(CYCLE_BASE_YEAR) + {4'd0, c4_reg, 2'd0} + 12'(yi);
            doy5_reg    <= doy_next;
            leap5_reg   <= yi == 2'd0;
            beyond5_reg <= beyond4_reg;
        end
    end

    // Month index is the number of later month starts already reached.
    always_comb
    begin
        midx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy5_reg >= month_start(4'(k), leap5_reg))
            begin
                midx = midx + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            midx6_reg   <= midx;
            year6_reg   <= year5_reg;
            doy6_reg    <= doy5_reg;
            leap6_reg   <= leap5_reg;
            beyond6_reg <= beyond5_reg;
        end
    end

    // Day of month, or the saturated last day when past the last year.
    assign day_off = doy6_reg - month_start(midx6_reg, leap6_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beyond_reg <= beyond6_reg;
            if (beyond6_reg)
            begin
                year_reg  <= 12'(LAST_YEAR);
                month_reg <= 4'd12;
                day_reg   <= 5'd31;
            end
            else
            begin
                year_reg  <= year6_reg;
                month_reg <= midx6_reg + 4'd1;
                day_reg   <= day_off[4:0] + 5'd1;
            end
        end
    end

    assign year   = year_reg;
    assign month  = month_reg;
    assign day    = day_reg;
    assign beyond = beyond_reg;

endmodule

// ===== hw/rtl/unix_epoch_to_calendar.sv =====
// Converts a Unix timestamp into calendar date, time of day and weekday.
// ts_in is a valid/ready sink of in_word_t words with the signed 33-bit timestamp in
// seconds; negative timestamps read as the epoch itself.
// cal_out is a valid/ready source of out_word_t words: year, month, day, hour, minute,
// second, weekday (0 is Sunday) and a flag for timestamps after the last supported year,
// where the date reads as December 31st of that year while time and weekday stay exact.
// Throughput is one word per cycle: eight register stages hold one word each, and every
// division is by a constant, done as a multiply by its reciprocal and one correction.
// The whole pipeline advances together; when cal_out holds a word that is not taken,
// every stage holds and ts_in.ready drops in the same cycle, so nothing is lost or repeated.
// Reset clears the stage valid bits only; the first word may be sent right after reset.
// Depends on uec_pkg, uec_stream_if, uec_day_split, uec_time_split and uec_date_split.
module unix_epoch_to_calendar
    import uec_pkg::*;
#(
    parameter int LAST_YEAR = DEFAULT_LAST_YEAR
)
(
    input  logic        clk,
    input  logic        rst_n,
    uec_stream_if.sink   ts_in,
    uec_stream_if.source cal_out
);

    localparam int STAGES = 8;

    logic              advance;
    logic [STAGES-1:0] valid_reg;
    logic [31:0]       t_reg;
    logic [31:0]       t_next;
    logic [15:0]       days;
    logic [16:0]       sod;
    out_word_t         word;

    // The pipeline moves whenever the output stage is empty or its word is taken.
    assign advance     = !valid_reg[STAGES-1] || cal_out.ready;
    assign ts_in.ready = advance;

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], ts_in.valid};
        end
    end

    // Input stage clamps negative timestamps to zero.
    assign t_next = ts_in.data.epoch_seconds[32] ? 32'd0 : ts_in.data.epoch_seconds[31:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg <= t_next;
        end
    end

    uec_day_split u_day_split (
        .clk  (clk),
        .en   (advance),
        .t    (t_reg),
        .days (days),
        .sod  (sod)
    );

    uec_time_split u_time_split (
        .clk    (clk),
        .en     (advance),
        .sod    (sod),
        .days   (days),
        .hour   (word.hour_of_day),
        .minute (word.minute_of_hour),
        .second (word.second_of_minute),
        .wday   (word.day_of_week)
    );

    uec_date_split #(
        .LAST_YEAR (LAST_YEAR)
    ) u_date_split (
        .clk    (clk),
        .en     (advance),
        .days   (days),
        .year   (word.cal_year),
        .month  (word.cal_month),
        .day    (word.cal_day),
        .beyond (word.beyond_limit)
    );

    assign cal_out.valid = valid_reg[STAGES-1];
    assign cal_out.data  = word;

endmodule
